// ----- sv/kmeans_lloyd_clustering_defines.svh -----
// ----------------------------------------------------------------------------
// K-means clustering assertion macros
// Shared property shorthands on clk / rst_n for the block's checks.
// ----------------------------------------------------------------------------
`ifndef KMEANS_LLOYD_CLUSTERING_DEFINES_SVH
`define KMEANS_LLOYD_CLUSTERING_DEFINES_SVH

// same-cycle implication
`define KML_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KML_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/kml_pkg.sv -----
// ----------------------------------------------------------------------------
// kml_pkg
// Types and codes shared by the K-means clustering block.
// ----------------------------------------------------------------------------
package kml_pkg;

  typedef enum logic [2:0] {
    OP_LOAD_POINT  = 3'd0,
    OP_LOAD_CENTER = 3'd1,
    OP_RUN         = 3'd2,
    OP_READ_ASSIGN = 3'd3,
    OP_READ_CENTER = 3'd4
  } kml_op_t;

  localparam logic [1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [1:0] REG_DIM_COUNT   = 2'd1;
  localparam logic [1:0] REG_CLUST_COUNT = 2'd2;
  localparam logic [1:0] REG_ITER_LIMIT  = 2'd3;

  localparam logic [47:0] TOTAL_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [9:0]         item_index;
    logic [3:0]         coord_index;
    logic signed [31:0] coord_value;
  } kml_in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [15:0]        iterations_run;
    logic [47:0]        total_distance;
    logic               converged;
  } kml_out_t;

  // control broadcast along the row of cluster cells
  typedef struct packed {
    logic        acc_clr;   // clear distance accumulators
    logic        dist_vld;  // pt carries a coordinate for distance
    logic        sum_vld;   // pt carries a coordinate for the selected sum
    logic        cnt_inc;   // count one point into the selected cluster
    logic        sum_clr;   // clear sums and sizes
    logic [31:0] pt;
    logic [7:0]  dim;
    logic [7:0]  sel;
    logic [8:0]  nk;
  } kml_ctl_t;

endpackage

// ----- sv/kml_div.sv -----
// ----------------------------------------------------------------------------
// kml_div
// Radix-2 restoring divider: signed sum by unsigned count, truncated to zero.
// ----------------------------------------------------------------------------
module kml_div import kml_pkg::*; #(
  parameter int SW  = 42,
  parameter int NPW = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [SW-1:0]  dividend,
  input  logic [NPW-1:0]        divisor,
  output logic                  done,
  output logic signed [31:0]    quotient
);

  localparam int CNTW = $clog2(SW + 1);

  logic            run_r, run_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0]   q_r, q_nxt;
  logic [NPW:0]    rem_r, rem_nxt;
  logic [NPW-1:0]  dvs_r, dvs_nxt;
  logic            neg_r, neg_nxt;
  logic [NPW:0]    shifted;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    shifted  = {rem_r[NPW-1:0], q_r[SW-1]};
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNTW'(SW);
      q_nxt   = dividend[SW-1] ? SW'(-dividend) : dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      neg_nxt = dividend[SW-1];
    end else if (run_r) begin
      // shift in one dividend bit, subtract where it fits
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = shifted - {1'b0, dvs_r};
        q_nxt   = {q_r[SW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[SW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? -q_r[31:0] : q_r[31:0];

endmodule

// ----- sv/kml_cell.sv -----
// ----------------------------------------------------------------------------
// kml_cell
// One cluster cell: holds a center, its running sums and size, measures the
// broadcast point and passes the running nearest center to its neighbor.
// ----------------------------------------------------------------------------
module kml_cell import kml_pkg::*; #(
  parameter int CELL_ID    = 0,
  parameter int MAX_DIMS   = 16,
  parameter int MAX_POINTS = 1024,
  parameter int BW         = 54,
  parameter int CW         = 4,
  parameter int SW         = 32 + $clog2(MAX_POINTS),
  parameter int NPW        = $clog2(MAX_POINTS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kml_ctl_t              ctl,
  input  logic                  ctr_we,
  input  logic signed [31:0]    ctr_wdata,
  input  logic [BW-1:0]         chain_dist_i,
  input  logic [CW-1:0]         chain_idx_i,
  output logic [BW-1:0]         chain_dist_o,
  output logic [CW-1:0]         chain_idx_o,
  output logic signed [31:0]    ctr_o,
  output logic signed [SW-1:0]  sum_o,
  output logic [NPW-1:0]        size_o
);

  localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  logic signed [31:0]   ctr_r [MAX_DIMS];
  logic signed [SW-1:0] sum_r [MAX_DIMS];
  logic [NPW-1:0]       size_r;
  logic [32:0]          diff_r;
  logic                 v1_r, v2_r;
  logic [48:0]          term_r;
  logic [BW-1:0]        acc_r;
  logic [BW-1:0]        cdist_r;
  logic [CW-1:0]        cidx_r;
  logic [DW-1:0]        dim;
  logic                 mine;
  logic                 active;
  logic                 own_win;
  logic [32:0]          mag;
  logic [65:0]          sq;

  assign dim     = ctl.dim[DW-1:0];
  assign mine    = (ctl.sel == 8'(CELL_ID));
  assign active  = (9'(CELL_ID) < ctl.nk);
  assign own_win = active && ((CELL_ID == 0) || (acc_r < chain_dist_i));
  assign mag     = diff_r[32] ? -diff_r : diff_r;
  assign sq      = {33'b0, mag} * {33'b0, mag};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctl.dist_vld;
      v2_r <= v1_r;
    end
    diff_r <= {ctl.pt[31], ctl.pt} - {ctr_r[dim][31], ctr_r[dim]};
    term_r <= sq[64:16];
    if (ctl.acc_clr) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + BW'(term_r);
    end
    // nearest so far, ties stay with the lower index upstream
    if (own_win) begin
      cdist_r <= acc_r;
      cidx_r  <= CW'(CELL_ID);
    end else begin
      cdist_r <= chain_dist_i;
      cidx_r  <= chain_idx_i;
    end
    if (ctr_we) begin
      ctr_r[dim] <= ctr_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.sum_clr) begin
      size_r <= '0;
      for (int i = 0; i < MAX_DIMS; i++) begin
        sum_r[i] <= '0;
      end
    end else begin
      if (ctl.cnt_inc && mine) begin
        size_r <= size_r + 1'b1;
      end
      if (ctl.sum_vld && mine) begin
        sum_r[dim] <= sum_r[dim] + {{(SW-32){ctl.pt[31]}}, ctl.pt};
      end
    end
  end

  assign chain_dist_o = cdist_r;
  assign chain_idx_o  = cidx_r;
  assign ctr_o        = ctr_r[dim];
  assign sum_o        = sum_r[dim];
  assign size_o       = size_r;

endmodule

// ----- sv/kmeans_lloyd_clustering.sv -----
// ----------------------------------------------------------------------------
// kmeans_lloyd_clustering
// K-means clustering by Lloyd iterations on signed Q16.16 coordinates.
// ----------------------------------------------------------------------------
// Usage: registers (point count, dimension count, cluster count, iteration
// limit) are written over the APB port while the block is idle. A command is
// taken when start is high and busy low. Loads give no result. Reads
// (assignment, center coordinate) give one result strobe on out_valid,
// registered from the read state. A run gives one result when it ends:
// iterations done, saturated total distance and a converged flag. The length
// of a run is set by the point memory port (one coordinate a cycle), the cell
// chain depth and the bit-serial divider (SW = 42 bits by default). After
// reset the assignment memory is cleared with busy high. Results are shown for
// one cycle only; the receiver cannot stall.
// ----------------------------------------------------------------------------
module kmeans_lloyd_clustering import kml_pkg::*; #(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_DIMS     = 16,
  parameter int MAX_CLUSTERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  kml_in_t     in_data,
  output logic        out_valid,
  output kml_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "kmeans_lloyd_clustering_defines.svh"

  localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CW  = $clog2(MAX_CLUSTERS);
  localparam int PW  = $clog2(MAX_POINTS);
  localparam int NPW = $clog2(MAX_POINTS + 1);
  localparam int AW  = $clog2(MAX_POINTS * MAX_DIMS);
  localparam int SW  = 32 + $clog2(MAX_POINTS);
  localparam int BW  = 49 + $clog2(MAX_DIMS + 1);
  localparam int SCW = DW + 3;
  localparam int MCW = $clog2(MAX_CLUSTERS + 1);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_READ  = 10'b00_0000_0100,
    S_ITER  = 10'b00_0000_1000,
    S_DIST  = 10'b00_0001_0000,
    S_MIN   = 10'b00_0010_0000,
    S_ACC   = 10'b00_0100_0000,
    S_DIV   = 10'b00_1000_0000,
    S_CHECK = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [10:0] point_count_r;
  logic [4:0]  dim_count_r;
  logic [4:0]  clust_count_r;
  logic [15:0] iter_limit_r;

  logic [NPW-1:0] np;
  logic [DW:0]    nd;
  logic [CW:0]    nk;

  logic signed [31:0] pt_mem [MAX_POINTS * MAX_DIMS];
  logic [CW-1:0]      asg_mem [MAX_POINTS];
  logic signed [31:0] pt_q_r;
  logic [CW-1:0]      asg_q_r;
  logic               rdv_r;
  logic [DW:0]        dq_r;

  logic [PW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [NPW-1:0] p_r, p_nxt;
  logic [SCW-1:0] s_r, s_nxt;
  logic [MCW-1:0] m_r, m_nxt;
  logic [CW:0]    k_r, k_nxt;
  logic [DW:0]    d_r, d_nxt;
  logic           div_wait_r, div_wait_nxt;
  logic [15:0]    iter_r, iter_nxt;
  logic [47:0]    total_r, total_nxt;
  logic [47:0]    prev_r, prev_nxt;
  logic           prev_vld_r, prev_vld_nxt;
  logic           conv_r, conv_nxt;
  logic [CW-1:0]  best_r, best_nxt;
  logic [2:0]     rd_op_r;
  logic           rd_ok_r;
  logic [9:0]     rd_item_r;
  logic [3:0]     rd_ci_r;
  logic           out_valid_r;
  kml_out_t       out_data_r, out_data_nxt;

  logic           accept;
  logic           issue;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  wr_addr;
  logic           pt_we;
  logic           asg_we;
  logic [PW-1:0]  asg_waddr;
  logic [CW-1:0]  asg_wdata;
  logic [BW:0]    total_sum;
  logic           div_start;
  logic           div_done;
  logic signed [31:0] div_q;
  logic           cfg_we;
  kml_ctl_t       ctl;

  logic [BW-1:0]        cdist [MAX_CLUSTERS+1];
  logic [CW-1:0]        cidx  [MAX_CLUSTERS+1];
  logic signed [31:0]   cctr  [MAX_CLUSTERS];
  logic signed [SW-1:0] csum  [MAX_CLUSTERS];
  logic [NPW-1:0]       csize [MAX_CLUSTERS];
  logic [MAX_CLUSTERS-1:0] ctr_we;
  logic signed [31:0]   ctr_wdata;

  // register file
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= 11'd1;
      dim_count_r   <= 5'd1;
      clust_count_r <= 5'd1;
      iter_limit_r  <= 16'd100;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_POINT_COUNT: point_count_r <= pwdata[10:0];
        REG_DIM_COUNT:   dim_count_r   <= pwdata[4:0];
        REG_CLUST_COUNT: clust_count_r <= pwdata[4:0];
        REG_ITER_LIMIT:  iter_limit_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_POINT_COUNT: prdata = {21'b0, point_count_r};
      REG_DIM_COUNT:   prdata = {27'b0, dim_count_r};
      REG_CLUST_COUNT: prdata = {27'b0, clust_count_r};
      REG_ITER_LIMIT:  prdata = {16'b0, iter_limit_r};
      default:         prdata = '0;
    endcase
  end

  // saturated working counts
  always_comb begin
    np = (32'(point_count_r) > 32'(MAX_POINTS)) ? NPW'(MAX_POINTS) : NPW'(point_count_r);
    nd = (32'(dim_count_r) > 32'(MAX_DIMS)) ? (DW+1)'(MAX_DIMS) : (DW+1)'(dim_count_r);
    if (clust_count_r == 5'd0) begin
      nk = (CW+1)'(1);
    end else if (32'(clust_count_r) > 32'(MAX_CLUSTERS)) begin
      nk = (CW+1)'(MAX_CLUSTERS);
    end else begin
      nk = (CW+1)'(clust_count_r);
    end
  end

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // point memory
  assign wr_addr = AW'(32'(in_data.item_index) * 32'(MAX_DIMS) + 32'(in_data.coord_index));
  assign rd_addr = AW'(32'(p_r) * 32'(MAX_DIMS) + 32'(s_r));
  assign pt_we   = accept && (in_data.opcode == OP_LOAD_POINT) &&
                   (32'(in_data.item_index) < 32'(MAX_POINTS)) &&
                   (32'(in_data.coord_index) < 32'(MAX_DIMS));
  assign issue   = ((state_r == S_DIST) || (state_r == S_ACC)) && (32'(s_r) < 32'(nd));

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[wr_addr] <= in_data.coord_value;
    end
    pt_q_r <= pt_mem[rd_addr];
  end

  // assignment memory
  always_comb begin
    asg_we    = 1'b0;
    asg_waddr = p_r[PW-1:0];
    asg_wdata = cidx[MAX_CLUSTERS];
    if (state_r == S_CLEAR) begin
      asg_we    = 1'b1;
      asg_waddr = clr_cnt_r;
      asg_wdata = '0;
    end else if ((state_r == S_MIN) && (m_r == MCW'(MAX_CLUSTERS))) begin
      asg_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (asg_we) begin
      asg_mem[asg_waddr] <= asg_wdata;
    end
    asg_q_r <= asg_mem[PW'(in_data.item_index)];
  end

  // cell control
  always_comb begin
    ctl          = '0;
    ctl.acc_clr  = (state_r == S_ITER) || ((state_r == S_ACC) && (32'(s_r) == 32'(nd)));
    ctl.dist_vld = rdv_r && (state_r == S_DIST);
    ctl.sum_vld  = rdv_r && (state_r == S_ACC);
    ctl.cnt_inc  = (state_r == S_ACC) && (s_r == '0);
    ctl.sum_clr  = (state_r == S_ITER);
    ctl.pt       = pt_q_r;
    ctl.sel      = 8'(best_r);
    ctl.nk       = 9'(nk);
    unique case (state_r)
      S_IDLE:  ctl.dim = 8'(in_data.coord_index);
      S_READ:  ctl.dim = 8'(rd_ci_r);
      S_DIV:   ctl.dim = 8'(d_r);
      default: ctl.dim = 8'(dq_r);
    endcase
  end

  always_comb begin
    ctr_we    = '0;
    ctr_wdata = in_data.coord_value;
    if (accept && (in_data.opcode == OP_LOAD_CENTER) &&
        (32'(in_data.item_index) < 32'(MAX_CLUSTERS)) &&
        (32'(in_data.coord_index) < 32'(MAX_DIMS))) begin
      ctr_we[CW'(in_data.item_index)] = 1'b1;
    end else if ((state_r == S_DIV) && div_done) begin
      ctr_we[k_r[CW-1:0]] = 1'b1;
      ctr_wdata           = div_q;
    end
  end

  assign cdist[0] = '0;
  assign cidx[0]  = '0;

  for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
    kml_cell #(
      .CELL_ID    (g),
      .MAX_DIMS   (MAX_DIMS),
      .MAX_POINTS (MAX_POINTS),
      .BW         (BW),
      .CW         (CW),
      .SW         (SW),
      .NPW        (NPW)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .ctr_we       (ctr_we[g]),
      .ctr_wdata    (ctr_wdata),
      .chain_dist_i (cdist[g]),
      .chain_idx_i  (cidx[g]),
      .chain_dist_o (cdist[g+1]),
      .chain_idx_o  (cidx[g+1]),
      .ctr_o        (cctr[g]),
      .sum_o        (csum[g]),
      .size_o       (csize[g])
    );
  end

  kml_div #(
    .SW  (SW),
    .NPW (NPW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (csum[k_r[CW-1:0]]),
    .divisor  (csize[k_r[CW-1:0]]),
    .done     (div_done),
    .quotient (div_q)
  );

  assign total_sum = {{(BW-47){1'b0}}, total_r} + {1'b0, cdist[MAX_CLUSTERS]};

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    p_nxt        = p_r;
    s_nxt        = s_r;
    m_nxt        = m_r;
    k_nxt        = k_r;
    d_nxt        = d_r;
    div_wait_nxt = div_wait_r;
    iter_nxt     = iter_r;
    total_nxt    = total_r;
    prev_nxt     = prev_r;
    prev_vld_nxt = prev_vld_r;
    conv_nxt     = conv_r;
    best_nxt     = best_r;
    div_start    = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (32'(clr_cnt_r) == 32'(MAX_POINTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_data.opcode) inside
            OP_RUN: begin
              iter_nxt     = '0;
              total_nxt    = '0;
              conv_nxt     = 1'b0;
              prev_vld_nxt = 1'b0;
              state_nxt    = (iter_limit_r == 16'd0) ? S_DONE : S_ITER;
            end
            OP_READ_ASSIGN, OP_READ_CENTER: state_nxt = S_READ;
            default: ;
          endcase
        end
      end
      S_READ: state_nxt = S_IDLE;
      S_ITER: begin
        iter_nxt  = iter_r + 1'b1;
        total_nxt = '0;
        p_nxt     = '0;
        s_nxt     = '0;
        k_nxt     = '0;
        d_nxt     = '0;
        state_nxt = (np == '0) ? S_DIV : S_DIST;
      end
      S_DIST: begin
        s_nxt = s_r + 1'b1;
        // hold until the last term has landed in the accumulators
        if (32'(s_r) == 32'(nd) + 32'd3) begin
          m_nxt     = '0;
          state_nxt = S_MIN;
        end
      end
      S_MIN: begin
        m_nxt = m_r + 1'b1;
        if (m_r == MCW'(MAX_CLUSTERS)) begin
          best_nxt  = cidx[MAX_CLUSTERS];
          total_nxt = (total_sum > (BW+1)'(TOTAL_MAX)) ? TOTAL_MAX : total_sum[47:0];
          s_nxt     = '0;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        s_nxt = s_r + 1'b1;
        if (32'(s_r) == 32'(nd)) begin
          s_nxt = '0;
          if (p_r == np - 1'b1) begin
            state_nxt = S_DIV;
          end else begin
            p_nxt     = p_r + 1'b1;
            state_nxt = S_DIST;
          end
        end
      end
      S_DIV: begin
        if (!div_wait_r) begin
          if (k_r == nk) begin
            state_nxt = S_CHECK;
          end else if ((nd == '0) || (csize[k_r[CW-1:0]] == '0)) begin
            // empty cluster keeps its center
            k_nxt = k_r + 1'b1;
            d_nxt = '0;
          end else begin
            div_start    = 1'b1;
            div_wait_nxt = 1'b1;
          end
        end else if (div_done) begin
          div_wait_nxt = 1'b0;
          if (d_r == nd - 1'b1) begin
            d_nxt = '0;
            k_nxt = k_r + 1'b1;
          end else begin
            d_nxt = d_r + 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (prev_vld_r && (total_r == prev_r)) begin
          conv_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          prev_nxt     = total_r;
          prev_vld_nxt = 1'b1;
          state_nxt    = (iter_r == iter_limit_r) ? S_DONE : S_ITER;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_data_nxt = '0;
    if (state_r == S_READ) begin
      if (rd_ok_r) begin
        out_data_nxt.read_value = (rd_op_r == OP_READ_ASSIGN) ? 32'(asg_q_r) :
                                  cctr[CW'(rd_item_r)];
      end
    end else if (state_r == S_DONE) begin
      out_data_nxt.iterations_run = iter_r;
      out_data_nxt.total_distance = total_r;
      out_data_nxt.converged      = conv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      div_wait_r  <= 1'b0;
      prev_vld_r  <= 1'b0;
      prev_r      <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      div_wait_r  <= div_wait_nxt;
      prev_vld_r  <= prev_vld_nxt;
      prev_r      <= prev_nxt;
      rdv_r       <= issue;
      out_valid_r <= (state_r == S_READ) || (state_r == S_DONE);
    end
    p_r      <= p_nxt;
    s_r      <= s_nxt;
    m_r      <= m_nxt;
    k_r      <= k_nxt;
    d_r      <= d_nxt;
    iter_r   <= iter_nxt;
    total_r  <= total_nxt;
    conv_r   <= conv_nxt;
    best_r   <= best_nxt;
    dq_r     <= s_r[DW:0];
    if (accept) begin
      rd_op_r   <= in_data.opcode;
      rd_item_r <= in_data.item_index;
      rd_ci_r   <= in_data.coord_index;
      rd_ok_r   <= (in_data.opcode == OP_READ_ASSIGN) ?
                   (32'(in_data.item_index) < 32'(MAX_POINTS)) :
                   ((32'(in_data.item_index) < 32'(MAX_CLUSTERS)) &&
                    (32'(in_data.coord_index) < 32'(MAX_DIMS)));
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `KML_ASSERT_NEXT(a_run_goes_busy, accept && (in_data.opcode == OP_RUN), busy, "run not busy")
  `KML_ASSERT_NOW(a_conv_has_iter, out_valid && out_data.converged,
                  out_data.iterations_run > 16'd1, "converged without two iterations")
  `KML_ASSERT_NOW(a_div_only_in_div, div_start, state_r == S_DIV, "divider started outside pass")
  `KML_ASSERT_NEXT(a_result_once, out_valid, !out_valid, "back to back results")

endmodule
